// ===== rtl/lru_key_value_cache_top_assert.svh =====
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shorthand for clocked checks that the top level runs at its end.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check the consequent in the cycle after the antecedent
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, transaction types, opcodes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvc_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int DATA_BITS  = 32;
   localparam int CAP_BITS   = 5;
   localparam int KEY_W      = (KEY_BITS < DATA_BITS) ? KEY_BITS : DATA_BITS;
   localparam int RANK_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);
   localparam int CAP_RESET  = 16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic                        opcode;
      logic signed [DATA_BITS-1:0] lookup_key;
      logic signed [DATA_BITS-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                        hit;
      logic signed [DATA_BITS-1:0] read_value;
      logic                        evicted;
      logic signed [DATA_BITS-1:0] evicted_key;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } status_type;

endpackage

// ===== rtl/lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The request is captured at the accepting edge. The match state then compares
// the key against all sixteen entries and locates the oldest and the lowest free
// entry. The update state, once the output register is free, updates values and
// recency ranks and loads the response register. A new request is taken in the
// cycle after the update, so the block takes no new transaction before it is
// through with the last one; the compare-then-update sequence over the entry
// registers sets that pace. The response sits in an output register, so the
// next request is accepted while a response waits; its update then holds
// until the waiting response leaves. csr_ready is always high; write capacity
// only when idle.
`timescale 1ns / 1ps

module lru_key_value_cache_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lkvc_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lkvc_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lkvc_pkg::CAP_BITS-1:0]   csr_data
);

   lkvc_pkg::cmd_type    ctrl_cmd;
   lkvc_pkg::status_type dp_status;

   assign csr_ready = 1'b1;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   lkvc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (ctrl_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`include "lru_key_value_cache_top_assert.svh"

   `LKVC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "accept while busy")
   `LKVC_ASSERT_NEXT(a_commit_shows_rsp, ctrl_cmd.commit, rsp_valid, "commit lost response")
   `LKVC_ASSERT_NOW(a_miss_reads_zero, rsp_valid && !rsp_data.hit, rsp_data.read_value == '0, "miss has value")
   `LKVC_ASSERT_NOW(a_evict_only_miss, rsp_valid && rsp_data.evicted, !rsp_data.hit, "evict on hit")

endmodule

// ===== rtl/lkvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Steps one transaction through capture, tag compare and store update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lkvc_pkg::status_type status,
   output lkvc_pkg::cmd_type    cmd
);

   lkvc_pkg::state_type state_ff;
   lkvc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkvc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lkvc_pkg::ST_MATCH;
            end
         end
         lkvc_pkg::ST_MATCH: begin
            state_in = lkvc_pkg::ST_UPDATE;
         end
         lkvc_pkg::ST_UPDATE: begin
            if (status.rsp_free) begin
               state_in = lkvc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.eval   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         lkvc_pkg::ST_MATCH: begin
            cmd.eval = 1'b1;
         end
         lkvc_pkg::ST_UPDATE: begin
            cmd.commit = status.rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/lkvc_datapath.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Entry store, recency ranks, tag compare, victim select and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lkvc_pkg::req_type                   req_data,
   input  logic                                csr_valid,
   input  logic [lkvc_pkg::CAP_BITS-1:0]       csr_data,
   input  lkvc_pkg::cmd_type                   cmd,
   output lkvc_pkg::status_type                status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lkvc_pkg::rsp_type                   rsp_data
);

   localparam int N  = lkvc_pkg::ENTRIES;
   localparam int KW = lkvc_pkg::KEY_W;
   localparam int DW = lkvc_pkg::DATA_BITS;
   localparam int RW = lkvc_pkg::RANK_BITS;
   localparam int CW = lkvc_pkg::COUNT_BITS;

   lkvc_pkg::req_type                  req_ff;
   logic [lkvc_pkg::CAP_BITS-1:0]      capacity_ff;
   logic [lkvc_pkg::CAP_BITS-1:0]      capacity_in;
   logic [CW-1:0]                      count_ff;
   logic [CW-1:0]                      count_in;
   logic [N-1:0]                       valid_ff;
   logic [N-1:0]                       valid_in;
   logic [KW-1:0]                      key_ff   [N];
   logic [KW-1:0]                      key_in   [N];
   logic [DW-1:0]                      value_ff [N];
   logic [DW-1:0]                      value_in [N];
   logic [RW-1:0]                      rank_ff  [N];
   logic [RW-1:0]                      rank_in  [N];
   logic [N-1:0]                       match_ff;
   logic [N-1:0]                       match_in;
   logic [N-1:0]                       victim_ff;
   logic [N-1:0]                       victim_in;
   logic [N-1:0]                       free_ff;
   logic [N-1:0]                       free_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   lkvc_pkg::rsp_type                  rsp_ff;
   lkvc_pkg::rsp_type                  rsp_in;

   logic [CW-1:0]                      cap_eff;
   logic                               cap_on;
   logic [RW-1:0]                      last_rank;
   logic [N-1:0]                       empty_slots;
   logic                               hit;
   logic                               is_put;
   logic                               insert;
   logic                               evict;
   logic [N-1:0]                       slot_oh;
   logic [RW-1:0]                      found_rank;
   logic [DW-1:0]                      found_value;
   logic [KW-1:0]                      victim_key;

   assign cap_eff = (32'(capacity_ff) > N) ? CW'(N) : CW'(capacity_ff);
   assign cap_on  = (cap_eff != '0);

   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   assign capacity_in = csr_valid ? csr_data : capacity_ff;

   // compare stage
   always_comb begin
      last_rank   = RW'(count_ff - CW'(1));
      empty_slots = ~valid_ff;
      free_in     = empty_slots & (~empty_slots + N'(1));
      for (int i = 0; i < N; i++) begin
         match_in[i]  = cap_on && valid_ff[i] && (key_ff[i] == req_ff.lookup_key[KW-1:0]);
         victim_in[i] = valid_ff[i] && (rank_ff[i] == last_rank);
      end
   end

   // update stage
   always_comb begin
      hit         = |match_ff;
      is_put      = (req_ff.opcode == lkvc_pkg::OP_PUT);
      insert      = cap_on && !hit && is_put;
      evict       = insert && (count_ff >= cap_eff);
      slot_oh     = evict ? victim_ff : free_ff;
      found_rank  = '0;
      found_value = '0;
      victim_key  = '0;
      for (int i = 0; i < N; i++) begin
         found_rank  = found_rank  | (match_ff[i]  ? rank_ff[i]  : '0);
         found_value = found_value | (match_ff[i]  ? value_ff[i] : '0);
         victim_key  = victim_key  | (victim_ff[i] ? key_ff[i]   : '0);
      end

      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < N; i++) begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         rank_in[i]  = rank_ff[i];
      end

      if (cmd.commit) begin
         for (int i = 0; i < N; i++) begin
            if (hit) begin
               if (match_ff[i]) begin
                  rank_in[i] = '0;
                  if (is_put) begin
                     value_in[i] = req_ff.write_value;
                  end
               end else if (valid_ff[i] && (rank_ff[i] < found_rank)) begin
                  rank_in[i] = rank_ff[i] + RW'(1);
               end
            end else if (insert) begin
               if (slot_oh[i]) begin
                  valid_in[i] = 1'b1;
                  key_in[i]   = req_ff.lookup_key[KW-1:0];
                  value_in[i] = req_ff.write_value;
                  rank_in[i]  = '0;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + RW'(1);
               end
            end
         end
         if (insert && !evict) begin
            count_in = count_ff + CW'(1);
         end
      end

      rsp_in.hit         = hit;
      rsp_in.read_value  = (hit && !is_put) ? found_value : '0;
      rsp_in.evicted     = evict;
      rsp_in.evicted_key = evict ? DW'(victim_key) : '0;

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lkvc_pkg::CAP_BITS'(lkvc_pkg::CAP_RESET);
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.eval) begin
         match_ff  <= match_in;
         victim_ff <= victim_in;
         free_ff   <= free_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
      for (int i = 0; i < N; i++) begin
         key_ff[i]   <= key_in[i];
         value_ff[i] <= value_in[i];
         rank_ff[i]  <= rank_in[i];
      end
   end

endmodule
